>>> src/ple_pkg.sv
// Shared types and constants of the positional list engine.
// Command codes, status codes and the default list depth.
// No dependencies.
`default_nettype none

package ple_pkg;

  // Default list capacity
  localparam int unsigned DEF_DEPTH = 16;

  // Field widths fixed by the interface
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned CNT_W    = 8;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Command codes
  localparam cmd_t CMD_INS_FRONT = 3'd0;
  localparam cmd_t CMD_INS_BACK  = 3'd1;
  localparam cmd_t CMD_INS_AT    = 3'd2;
  localparam cmd_t CMD_DEL_FRONT = 3'd3;
  localparam cmd_t CMD_DEL_BACK  = 3'd4;
  localparam cmd_t CMD_DEL_AT    = 3'd5;
  localparam cmd_t CMD_SEARCH    = 3'd6;
  localparam cmd_t CMD_DUMP      = 3'd7;

  // Status codes
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_EMPTY    = 3'd1;
  localparam status_t ST_FULL     = 3'd2;
  localparam status_t ST_BADPOS   = 3'd3;
  localparam status_t ST_NOTFOUND = 3'd4;

endpackage : ple_pkg

`default_nettype wire

>>> src/positional_list_engine_unit.sv
// Positional list engine: ordered list of signed 32-bit values with
// insert, delete, search and dump commands. Depends on ple_pkg.
// The list is kept in a one-read one-write memory walked by a sequencer.
//
//  Channel | Dir | Handshake             | Contents
//  --------+-----+-----------------------+--------------------------------
//  in_     | in  | in_tvalid/in_tready   | command in tuser, value/position
//  out_    | out | out_tvalid/out_tready | status in tuser, last in tlast
//
// Insert and delete shift entries one slot each through the memory port (up
// to DEPTH - 1 moves); search reads entries until a match or the end of the
// list; dump streams every entry out. One entry crosses the memory port per
// cycle, except while a dump waits for a busy result register.
// Reset (rst_n low, synchronous) empties the list; memory contents are not
// cleared. in_tready is high only between requests; the result register
// lets a new request enter while the previous result still waits.

`default_nettype none

module positional_list_engine_unit
  import ple_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [31:0] value, [39:32] position
  input  wire logic [2:0]  in_tuser,   // [2:0] command
  // Result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [7:0] found_index, [39:8] element,
                                       // [47:40] count
  output logic [2:0]       out_tuser,  // [2:0] status
  output logic             out_tlast   // last result of the request
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SHIFT  = 3'd1;
  localparam logic [2:0] S_FINISH = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DUMP   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  // List storage
  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data_r;

  // Control and working registers
  logic [2:0]       state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [VAL_W-1:0] value_r, value_nxt;
  logic [AW-1:0]    slot_r, slot_nxt;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             pend_r, pend_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  status_t          res_status_r, res_status_nxt;
  logic [AW-1:0]    res_idx_r, res_idx_nxt;

  // Result register
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r;
  logic [IDX_W-1:0] out_found_r;
  logic [VAL_W-1:0] out_elem_r;
  logic [CNT_W-1:0] out_count_r;
  logic             out_last_r;

  // Memory port controls
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [VAL_W-1:0] wr_data;

  // Result load controls
  logic             load_out;
  status_t          ld_status;
  logic [IDX_W-1:0] ld_found;
  logic [VAL_W-1:0] ld_elem;
  logic             ld_last;

  // Request decode
  cmd_t             in_cmd;
  logic [VAL_W-1:0] in_value;
  logic [POS_W-1:0] in_pos;
  logic [8:0]       pos9;
  logic [8:0]       cnt9;
  logic [AW-1:0]    pos_slot;
  logic             in_acc;
  logic             out_free;
  logic             is_ins;
  logic             is_del;
  logic [AW-1:0]    ins_slot;
  logic [AW-1:0]    del_slot;
  logic             ins_bad;
  logic             del_bad;

  assign in_cmd   = in_tuser;
  assign in_value = in_tdata[31:0];
  assign in_pos   = in_tdata[39:32];
  assign pos9     = {1'b0, in_pos};
  assign cnt9     = 9'(count_r);
  assign pos_slot = AW'(in_pos - 8'd1);

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign is_ins = (in_cmd == CMD_INS_FRONT) || (in_cmd == CMD_INS_BACK) ||
                  (in_cmd == CMD_INS_AT);
  assign is_del = (in_cmd == CMD_DEL_FRONT) || (in_cmd == CMD_DEL_BACK) ||
                  (in_cmd == CMD_DEL_AT);

  // Pick the target slot of an insert or delete
  always_comb begin
    unique case (in_cmd)
      CMD_INS_FRONT: ins_slot = '0;
      CMD_INS_BACK:  ins_slot = AW'(count_r);
      default:       ins_slot = pos_slot;
    endcase
    unique case (in_cmd)
      CMD_DEL_FRONT: del_slot = '0;
      CMD_DEL_BACK:  del_slot = AW'(count_r - CW'(1));
      default:       del_slot = pos_slot;
    endcase
  end

  assign ins_bad = (in_cmd == CMD_INS_AT) &&
                   ((in_pos == '0) || (pos9 > cnt9 + 9'd1));
  assign del_bad = (in_cmd == CMD_DEL_AT) &&
                   ((in_pos == '0) || (pos9 > cnt9));

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    value_nxt      = value_r;
    slot_nxt       = slot_r;
    ptr_nxt        = ptr_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;

    rd_en     = 1'b0;
    rd_addr   = ptr_r;
    wr_en     = 1'b0;
    wr_addr   = (cmd_r == CMD_DEL_FRONT || cmd_r == CMD_DEL_BACK ||
                 cmd_r == CMD_DEL_AT) ? idx_r - AW'(1) : idx_r + AW'(1);
    wr_data   = rd_data_r;

    load_out  = 1'b0;
    ld_status = res_status_r;
    ld_found  = IDX_W'(res_idx_r);
    ld_elem   = '0;
    ld_last   = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt     = in_cmd;
          value_nxt   = in_value;
          pend_nxt    = 1'b0;
          res_idx_nxt = '0;
          if (is_ins) begin
            slot_nxt = ins_slot;
            ptr_nxt  = AW'(count_r - CW'(1));
            cnt_nxt  = count_r - CW'(ins_slot);
            if (count_r == CW'(DEPTH)) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_DONE;
            end else if (ins_bad) begin
              res_status_nxt = ST_BADPOS;
              state_nxt      = S_DONE;
            end else begin
              res_status_nxt = ST_OK;
              state_nxt      = S_SHIFT;
            end
          end else if (is_del) begin
            slot_nxt = del_slot;
            ptr_nxt  = del_slot + AW'(1);
            cnt_nxt  = count_r - CW'(1) - CW'(del_slot);
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_DONE;
            end else if (del_bad) begin
              res_status_nxt = ST_BADPOS;
              state_nxt      = S_DONE;
            end else begin
              res_status_nxt = ST_OK;
              state_nxt      = S_SHIFT;
            end
          end else if (in_cmd == CMD_SEARCH) begin
            ptr_nxt        = '0;
            cnt_nxt        = count_r;
            res_status_nxt = ST_NOTFOUND;
            state_nxt      = S_SCAN;
          end else begin
            ptr_nxt = '0;
            cnt_nxt = count_r;
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_DUMP;
            end
          end
        end
      end

      // Move one entry per cycle: read the source, write it one slot over
      S_SHIFT: begin
        wr_en = pend_r;
        if (cnt_r == '0) begin
          pend_nxt  = 1'b0;
          state_nxt = S_FINISH;
        end else begin
          rd_en    = 1'b1;
          idx_nxt  = ptr_r;
          ptr_nxt  = (cmd_r == CMD_DEL_FRONT || cmd_r == CMD_DEL_BACK ||
                      cmd_r == CMD_DEL_AT) ? ptr_r + AW'(1) : ptr_r - AW'(1);
          cnt_nxt  = cnt_r - CW'(1);
          pend_nxt = 1'b1;
        end
      end

      // For an insert, drop the new value into its slot; update the count either way
      S_FINISH: begin
        if (cmd_r == CMD_INS_FRONT || cmd_r == CMD_INS_BACK ||
            cmd_r == CMD_INS_AT) begin
          wr_en     = 1'b1;
          wr_addr   = slot_r;
          wr_data   = value_r;
          count_nxt = count_r + CW'(1);
        end else begin
          count_nxt = count_r - CW'(1);
        end
        state_nxt = S_DONE;
      end

      // Compare the entry read last cycle while reading the next one
      S_SCAN: begin
        if (pend_r && (rd_data_r == value_r)) begin
          res_status_nxt = ST_OK;
          res_idx_nxt    = idx_r;
          pend_nxt       = 1'b0;
          state_nxt      = S_DONE;
        end else if (cnt_r == '0) begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_DONE;
          end
        end else begin
          rd_en    = 1'b1;
          idx_nxt  = ptr_r;
          ptr_nxt  = ptr_r + AW'(1);
          cnt_nxt  = cnt_r - CW'(1);
          pend_nxt = 1'b1;
        end
      end

      // Stream entries out, holding the read when the result register is busy
      S_DUMP: begin
        if (pend_r && out_free) begin
          load_out  = 1'b1;
          ld_status = ST_OK;
          ld_found  = '0;
          ld_elem   = rd_data_r;
          ld_last   = (cnt_r == '0);
          if (cnt_r == '0) begin
            state_nxt = S_IDLE;
          end
        end
        if ((cnt_r != '0) && (!pend_r || out_free)) begin
          rd_en    = 1'b1;
          ptr_nxt  = ptr_r + AW'(1);
          cnt_nxt  = cnt_r - CW'(1);
          pend_nxt = 1'b1;
        end else if (pend_r && out_free) begin
          pend_nxt = 1'b0;
        end
      end

      // Hand the single result to the result register
      S_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  // Memory port: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    value_r      <= value_nxt;
    slot_r       <= slot_nxt;
    ptr_r        <= ptr_nxt;
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= ld_status;
      out_found_r  <= ld_found;
      out_elem_r   <= ld_elem;
      out_count_r  <= CNT_W'(count_r);
      out_last_r   <= ld_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_count_r, out_elem_r, out_found_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  // Count never exceeds the capacity
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count above capacity");

  // An accepted request keeps the input closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input ready right after a request");

  // A successful insert grows the list by one
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && wr_en) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not grow the count");

  // A result that is not the last one is always a good dump entry
  a_mid_result_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && !ld_last) |-> (state_r == S_DUMP && ld_status == ST_OK))
    else $error("non-final result outside a dump");

  // The result register is only reloaded when it is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> out_free)
    else $error("result overwritten before it was taken");

endmodule : positional_list_engine_unit

`default_nettype wire

>>> test/positional_list_engine_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for positional_list_engine_unit: directed table, then random
// list traffic checked against a list mirror kept in the testbench. Depends on ple_pkg.

module positional_list_engine_unit_tb;
  import ple_pkg::*;

  localparam int unsigned DEPTH      = DEF_DEPTH;
  localparam int          RAND_ITEMS = 240;
  localparam int          PHASE_LEN  = 35;
  localparam int          LONG_HOLD  = 250;
  localparam int          IDLE_LIMIT = 3000;
  localparam int          TAIL_CYCLES = 40;
  localparam int          DIR_ROWS   = 27;

  // One result as the block reports it
  typedef struct packed {
    status_t     status;
    logic [7:0]  idx;
    logic [31:0] element;
    logic [7:0]  count;
    logic        last;
  } result_t;

  // One row of the directed table; typed rows carry their own expected result
  typedef struct {
    cmd_t        cmd;
    logic [31:0] val;
    logic [7:0]  pos;
    int          rep;
    bit          typed;
    status_t     st;
    logic [7:0]  cnt;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // [31:0] value, [39:32] position
  logic [2:0]  in_tuser = '0;   // [2:0] command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // [7:0] found_index, [39:8] element, [47:40] count
  logic [2:0]  out_tuser;       // [2:0] status
  logic        out_tlast;

  logic [31:0] list_mirror[$];
  result_t     step_results[$];
  result_t     pending_results[$];
  row_t        dir_rows[DIR_ROWS];
  int          error_count = 0;
  int          idle_cycles = 0;
  int          in_gap_pct = 30;
  int          out_stall_pct = 30;
  bit          hold_req = 1'b0;

  positional_list_engine_unit #(.DEPTH(DEPTH)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Apply one command to the list mirror and collect the results it gives
  task automatic apply_command(cmd_t cmd, logic [31:0] val, logic [7:0] pos);
    result_t r;
    int      n;
    int      p;
    bit      hit;
    step_results.delete();
    n = list_mirror.size();
    p = pos;
    hit = 1'b0;
    r.status = ST_OK;
    r.idx = '0;
    r.element = '0;
    r.last = 1'b1;
    case (cmd)
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
        // full is checked before the position
        if (n >= DEPTH) r.status = ST_FULL;
        else if (cmd == CMD_INS_FRONT) list_mirror.push_front(val);
        else if (cmd == CMD_INS_BACK) list_mirror.push_back(val);
        else if (p == 0 || p > n + 1) r.status = ST_BADPOS;
        else list_mirror.insert(p - 1, val);
      end
      CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
        if (n == 0) r.status = ST_EMPTY;
        else if (cmd == CMD_DEL_FRONT) void'(list_mirror.pop_front());
        else if (cmd == CMD_DEL_BACK) void'(list_mirror.pop_back());
        else if (p == 0 || p > n) r.status = ST_BADPOS;
        else list_mirror.delete(p - 1);
      end
      CMD_SEARCH: begin
        // first match wins; an empty list is a miss
        r.status = ST_NOTFOUND;
        for (int i = 0; i < n; i++) begin
          if (!hit && list_mirror[i] == val) begin
            hit = 1'b1;
            r.status = ST_OK;
            r.idx = i[7:0];
          end
        end
      end
      CMD_DUMP: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < n; i++) begin
            r.element = list_mirror[i];
            r.count = n[7:0];
            r.last = (i == n - 1);
            step_results.push_back(r);
          end
        end
      end
    endcase
    if (step_results.size() == 0) begin
      r.count = 8'(list_mirror.size());
      step_results.push_back(r);
    end
  endtask

  // Offer one request, wait for its handshake, then record what it should give
  task automatic send_request(cmd_t cmd, logic [31:0] val, logic [7:0] pos,
                              bit typed, status_t st, logic [7:0] cnt);
    int      g;
    result_t r;
    g = ($urandom_range(0, 99) < in_gap_pct) ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {pos, val};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_command(cmd, val, pos);
    if (typed) begin
      r.status = st;
      r.idx = '0;
      r.element = '0;
      r.count = cnt;
      r.last = 1'b1;
      pending_results.push_back(r);
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
  endtask

  // Values: often one already in the list, sometimes an extreme
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30 && list_mirror.size() > 0)
      return list_mirror[$urandom_range(0, list_mirror.size() - 1)];
    if (r < 40) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  // Positions: mostly inside the legal range, the rest anywhere
  function automatic logic [7:0] pick_position(int span);
    if (span < 1) span = 1;
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(1, span));
    return 8'($urandom_range(0, 255));
  endfunction

  // Result side: random stalls, a long hold-off on request
  initial begin
    int stall_left;
    int cyc;
    stall_left = 0;
    cyc = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: out_stall_pct = 0;
          1: out_stall_pct = 20;
          default: out_stall_pct = 50;
        endcase
      end
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 99) < out_stall_pct) stall_left = gap_len();
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with none expected: status %0d count %0d",
                                  out_tuser, out_tdata[47:40]));
      end else begin
        e = pending_results.pop_front();
        if (out_tuser !== e.status)
          report_mismatch($sformatf("status got %0d exp %0d", out_tuser, e.status));
        if (out_tdata[7:0] !== e.idx)
          report_mismatch($sformatf("found_index got %0d exp %0d", out_tdata[7:0], e.idx));
        if (out_tdata[39:8] !== e.element)
          report_mismatch($sformatf("element got %h exp %h", out_tdata[39:8], e.element));
        if (out_tdata[47:40] !== e.count)
          report_mismatch($sformatf("count got %0d exp %0d", out_tdata[47:40], e.count));
        if (out_tlast !== e.last)
          report_mismatch($sformatf("last got %0b exp %0b", out_tlast, e.last));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int      n;
    int      r;
    bit      grow;
    cmd_t    cmd;
    // cmd, value, position, repeat, typed, status, count
    dir_rows = '{
      '{CMD_DUMP,      32'h0,          8'd0,   1, 1'b1, ST_EMPTY,    8'd0},
      '{CMD_DEL_FRONT, 32'h0,          8'd0,   1, 1'b1, ST_EMPTY,    8'd0},
      '{CMD_DEL_BACK,  32'h0,          8'd0,   1, 1'b1, ST_EMPTY,    8'd0},
      '{CMD_DEL_AT,    32'h0,          8'd1,   1, 1'b1, ST_EMPTY,    8'd0},
      '{CMD_SEARCH,    32'h0,          8'd0,   1, 1'b1, ST_NOTFOUND, 8'd0},
      '{CMD_INS_AT,    32'h1,          8'd0,   1, 1'b1, ST_BADPOS,   8'd0},
      '{CMD_INS_AT,    32'h1,          8'd2,   1, 1'b1, ST_BADPOS,   8'd0},
      '{CMD_INS_AT,    32'h7FFF_FFFF,  8'd1,   1, 1'b1, ST_OK,       8'd1},
      '{CMD_INS_FRONT, 32'h8000_0000,  8'd0,   1, 1'b1, ST_OK,       8'd2},
      '{CMD_INS_BACK,  32'hFFFF_FFFF,  8'd255, 1, 1'b1, ST_OK,       8'd3},
      '{CMD_INS_AT,    32'h0,          8'd4,   1, 1'b1, ST_OK,       8'd4},
      '{CMD_INS_AT,    32'h1234_5678,  8'd255, 1, 1'b1, ST_BADPOS,   8'd4},
      '{CMD_SEARCH,    32'hFFFF_FFFF,  8'd0,   1, 1'b0, ST_OK,       8'd0},
      '{CMD_SEARCH,    32'h7FFF_FFFF,  8'd0,   1, 1'b0, ST_OK,       8'd0},
      '{CMD_DUMP,      32'h0,          8'd0,   1, 1'b0, ST_OK,       8'd0},
      '{CMD_DEL_AT,    32'h0,          8'd0,   1, 1'b1, ST_BADPOS,   8'd4},
      '{CMD_DEL_AT,    32'h0,          8'd5,   1, 1'b1, ST_BADPOS,   8'd4},
      '{CMD_DEL_AT,    32'h0,          8'd2,   1, 1'b0, ST_OK,       8'd0},
      '{CMD_INS_BACK,  32'h5A5A_5A5A,  8'd0,  13, 1'b0, ST_OK,       8'd0},
      '{CMD_INS_FRONT, 32'h1,          8'd1,   1, 1'b1, ST_FULL,     8'd16},
      '{CMD_INS_AT,    32'h1,          8'd0,   1, 1'b1, ST_FULL,     8'd16},
      '{CMD_INS_BACK,  32'h1,          8'd0,   1, 1'b1, ST_FULL,     8'd16},
      '{CMD_SEARCH,    32'h5A5A_5A5A,  8'd0,   1, 1'b0, ST_OK,       8'd0},
      '{CMD_DUMP,      32'h0,          8'd0,   1, 1'b0, ST_OK,       8'd0},
      '{CMD_DEL_AT,    32'h0,          8'd16,  1, 1'b0, ST_OK,       8'd0},
      '{CMD_DEL_FRONT, 32'h0,          8'd0,   1, 1'b0, ST_OK,       8'd0},
      '{CMD_DEL_BACK,  32'h0,          8'd0,   1, 1'b0, ST_OK,       8'd0}
    };

    // Hold reset, then release it
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      repeat (dir_rows[i].rep)
        send_request(dir_rows[i].cmd, dir_rows[i].val, dir_rows[i].pos,
                     dir_rows[i].typed, dir_rows[i].st, dir_rows[i].cnt);
    end

    // Random traffic, alternating between filling and draining the list
    grow = 1'b1;
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k % PHASE_LEN == 0) begin
        grow = ~grow;
        case ($urandom_range(0, 2))
          0: in_gap_pct = 0;
          1: in_gap_pct = 25;
          default: in_gap_pct = 60;
        endcase
      end
      if (k == 60 || k == 190) hold_req = 1'b1;
      n = list_mirror.size();
      r = $urandom_range(0, 99);
      if (r < (grow ? 50 : 20)) begin
        case ($urandom_range(0, 2))
          0: cmd = CMD_INS_FRONT;
          1: cmd = CMD_INS_BACK;
          default: cmd = CMD_INS_AT;
        endcase
      end else if (r < 68) begin
        case ($urandom_range(0, 2))
          0: cmd = CMD_DEL_FRONT;
          1: cmd = CMD_DEL_BACK;
          default: cmd = CMD_DEL_AT;
        endcase
      end else if (r < 88) begin
        cmd = CMD_SEARCH;
      end else begin
        cmd = CMD_DUMP;
      end
      send_request(cmd, pick_value(),
                   pick_position((cmd == CMD_INS_AT) ? n + 1 : n),
                   1'b0, ST_OK, 8'd0);
    end
    in_tvalid <= 1'b0;

    // Drain outstanding results, then let the block settle
    while (pending_results.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
